>>> design/xts_pkg.sv
// xts_pkg: shared types and constants for the xml token scanner
// token codes, scanner modes, character codes, queue sizing; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package xts_pkg;

  localparam int OUT_W = 24;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = 2;
  localparam int Q_LW = 3;

  // token codes
  localparam logic [3:0] TK_TEXT    = 4'd0;
  localparam logic [3:0] TK_START   = 4'd1;
  localparam logic [3:0] TK_END     = 4'd2;
  localparam logic [3:0] TK_SELF    = 4'd3;
  localparam logic [3:0] TK_CLOSE   = 4'd4;
  localparam logic [3:0] TK_ATTR    = 4'd5;
  localparam logic [3:0] TK_DECL    = 4'd6;
  localparam logic [3:0] TK_COMMENT = 4'd7;
  localparam logic [3:0] TK_EOF     = 4'd8;

  // character codes
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUOT  = 8'h22;

  typedef enum logic [3:0] {
    M_TEXT, M_LT, M_BANG, M_BANG_DASH, M_TAG_NAME, M_CLOSE, M_DECL,
    M_COMMENT, M_TAG_IDLE, M_TAG_SLASH, M_ATTR_NAME, M_ATTR_AFTER,
    M_VALUE_WAIT, M_VALUE_QUOTED, M_VALUE_PLAIN
  } mode_t;

  typedef struct packed {
    logic [3:0]       ttype;
    logic [OUT_W-1:0] name_start;
    logic [OUT_W-1:0] name_length;
    logic [OUT_W-1:0] value_start;
    logic [OUT_W-1:0] value_length;
    logic             has_value;
    logic             last;
  } token_t;

  // tokens produced by one byte
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  typedef struct packed {
    logic [Q_LW-1:0] level;
  } qstat_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0b) ||
           (b == 8'h0c) || (b == 8'h0d);
  endfunction

endpackage
`default_nettype wire

>>> design/xts_front.sv
// xts_front: byte scanner, mode tracking and span bookkeeping
// produces up to two tokens per byte; depends on xts_pkg
`timescale 1ns / 1ps
`default_nettype none
module xts_front #(
  parameter int POSITION_BITS = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    byte_in,
  input  wire logic          end_of_input,
  output xts_pkg::push_t     push
);

  localparam int PB = POSITION_BITS;
  localparam int WB = (PB > xts_pkg::OUT_W) ? PB : xts_pkg::OUT_W;

  typedef struct packed {
    xts_pkg::mode_t mode;
    logic [PB-1:0]  a_start;
    logic [PB-1:0]  a_len;
    logic [PB-1:0]  b_start;
    logic [7:0]     quote;
    logic [7:0]     la0;
    logic [7:0]     la1;
    logic           nonblank;
  } scan_t;

  typedef struct packed {
    scan_t           sc;
    logic            again;
    logic            emit;
    xts_pkg::token_t tok;
  } pass_t;

  scan_t         state;
  logic [PB-1:0] position;
  logic          end_sent;

  function automatic logic [xts_pkg::OUT_W-1:0] ow(logic [PB-1:0] v);
    logic [WB-1:0] w;
    w = WB'(v);
    return w[xts_pkg::OUT_W-1:0];
  endfunction

  function automatic logic [PB-1:0] sat_inc(logic [PB-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [PB-1:0] len_to(logic [PB-1:0] s, logic [PB-1:0] e);
    return (e >= s) ? e - s : '0;
  endfunction

  function automatic xts_pkg::token_t mk(logic [3:0] t, logic [PB-1:0] ns,
                                          logic [PB-1:0] nl, logic [PB-1:0] vs,
                                          logic [PB-1:0] vl, logic hv);
    xts_pkg::token_t k;
    k.ttype = t;
    k.name_start = ow(ns);
    k.name_length = ow(nl);
    k.value_start = ow(vs);
    k.value_length = ow(vl);
    k.has_value = hv;
    k.last = 1'b0;
    return k;
  endfunction

  // one dispatch of the scanner on a byte
  function automatic pass_t run(pass_t p, logic [7:0] b, logic [PB-1:0] pos);
    pass_t         r;
    scan_t         s;
    logic [PB-1:0] pn;
    logic [PB-1:0] e;
    logic          ws;
    r = p;
    r.again = 1'b0;
    r.emit = 1'b0;
    r.tok = '0;
    s = p.sc;
    pn = sat_inc(pos);
    ws = xts_pkg::is_ws(b);
    e = '0;
    case (s.mode)
      xts_pkg::M_TEXT: begin
        if (b == xts_pkg::CH_LT) begin
          if (s.nonblank) begin
            r.emit = 1'b1;
            r.tok = mk(xts_pkg::TK_TEXT, '0, '0, s.a_start, len_to(s.a_start, pos), 1'b0);
          end
          s.mode = xts_pkg::M_LT;
        end else if (!ws) begin
          s.nonblank = 1'b1;
        end
      end
      xts_pkg::M_LT, xts_pkg::M_BANG: begin
        if (b == xts_pkg::CH_QUEST && s.mode == xts_pkg::M_LT) begin
          s.mode = xts_pkg::M_DECL;
          s.a_start = pn;
          s.la0 = '0;
          s.la1 = '0;
        end else if (b == xts_pkg::CH_BANG && s.mode == xts_pkg::M_LT) begin
          s.mode = xts_pkg::M_BANG;
        end else if (b == xts_pkg::CH_DASH && s.mode == xts_pkg::M_BANG) begin
          s.a_start = pos;
          s.mode = xts_pkg::M_BANG_DASH;
        end else if (b == xts_pkg::CH_SLASH) begin
          s.mode = xts_pkg::M_CLOSE;
          s.a_start = pn;
        end else begin
          s.a_start = pos;
          s.mode = xts_pkg::M_TAG_NAME;
          r.again = 1'b1;
        end
      end
      xts_pkg::M_BANG_DASH: begin
        if (b == xts_pkg::CH_DASH) begin
          s.mode = xts_pkg::M_COMMENT;
          s.a_start = pn;
          s.la0 = '0;
          s.la1 = '0;
        end else begin
          s.mode = xts_pkg::M_TAG_NAME;
          r.again = 1'b1;
        end
      end
      xts_pkg::M_TAG_NAME: begin
        if (ws || b == xts_pkg::CH_GT || b == xts_pkg::CH_SLASH) begin
          r.emit = 1'b1;
          r.tok = mk(xts_pkg::TK_START, s.a_start, len_to(s.a_start, pos), '0, '0, 1'b0);
          s.mode = xts_pkg::M_TAG_IDLE;
          r.again = 1'b1;
        end
      end
      xts_pkg::M_CLOSE: begin
        if (b == xts_pkg::CH_GT) begin
          r.emit = 1'b1;
          r.tok = mk(xts_pkg::TK_CLOSE, s.a_start, len_to(s.a_start, pos), '0, '0, 1'b0);
          s.mode = xts_pkg::M_TEXT;
          s.a_start = pn;
          s.nonblank = 1'b0;
        end
      end
      xts_pkg::M_DECL, xts_pkg::M_COMMENT: begin
        if (s.mode == xts_pkg::M_DECL && b == xts_pkg::CH_GT &&
            s.la0 == xts_pkg::CH_QUEST) begin
          e = (pos > PB'(1'b0)) ? pos - PB'(1) : '0;
          r.emit = 1'b1;
          r.tok = mk(xts_pkg::TK_DECL, '0, '0, s.a_start, len_to(s.a_start, e), 1'b0);
          s.mode = xts_pkg::M_TEXT;
          s.a_start = pn;
          s.nonblank = 1'b0;
        end else if (s.mode == xts_pkg::M_COMMENT && b == xts_pkg::CH_GT &&
                     s.la0 == xts_pkg::CH_DASH && s.la1 == xts_pkg::CH_DASH) begin
          e = (pos > PB'(1)) ? pos - PB'(2) : '0;
          r.emit = 1'b1;
          r.tok = mk(xts_pkg::TK_COMMENT, '0, '0, s.a_start, len_to(s.a_start, e), 1'b0);
          s.mode = xts_pkg::M_TEXT;
          s.a_start = pn;
          s.nonblank = 1'b0;
        end else begin
          s.la1 = s.la0;
          s.la0 = b;
        end
      end
      xts_pkg::M_TAG_IDLE: begin
        if (b == xts_pkg::CH_GT) begin
          r.emit = 1'b1;
          r.tok = mk(xts_pkg::TK_END, '0, '0, '0, '0, 1'b0);
          s.mode = xts_pkg::M_TEXT;
          s.a_start = pn;
          s.nonblank = 1'b0;
        end else if (b == xts_pkg::CH_SLASH) begin
          s.mode = xts_pkg::M_TAG_SLASH;
        end else if (b == xts_pkg::CH_EQ) begin
          s.a_start = pos;
          s.a_len = '0;
          s.mode = xts_pkg::M_VALUE_WAIT;
        end else if (!ws) begin
          s.a_start = pos;
          s.mode = xts_pkg::M_ATTR_NAME;
        end
      end
      xts_pkg::M_TAG_SLASH: begin
        if (b == xts_pkg::CH_GT) begin
          r.emit = 1'b1;
          r.tok = mk(xts_pkg::TK_SELF, '0, '0, '0, '0, 1'b0);
          s.mode = xts_pkg::M_TEXT;
          s.a_start = pn;
          s.nonblank = 1'b0;
        end else begin
          s.mode = xts_pkg::M_TAG_IDLE;
          r.again = 1'b1;
        end
      end
      xts_pkg::M_ATTR_NAME: begin
        if (ws) begin
          s.a_len = len_to(s.a_start, pos);
          s.mode = xts_pkg::M_ATTR_AFTER;
        end else if (b == xts_pkg::CH_EQ) begin
          s.a_len = len_to(s.a_start, pos);
          s.mode = xts_pkg::M_VALUE_WAIT;
        end else if (b == xts_pkg::CH_GT || b == xts_pkg::CH_SLASH) begin
          s.a_len = len_to(s.a_start, pos);
          r.emit = 1'b1;
          r.tok = mk(xts_pkg::TK_ATTR, s.a_start, s.a_len, '0, '0, 1'b0);
          s.mode = xts_pkg::M_TAG_IDLE;
          r.again = 1'b1;
        end
      end
      xts_pkg::M_ATTR_AFTER: begin
        if (b == xts_pkg::CH_EQ) begin
          s.mode = xts_pkg::M_VALUE_WAIT;
        end else if (!ws) begin
          r.emit = 1'b1;
          r.tok = mk(xts_pkg::TK_ATTR, s.a_start, s.a_len, '0, '0, 1'b0);
          s.mode = xts_pkg::M_TAG_IDLE;
          r.again = 1'b1;
        end
      end
      xts_pkg::M_VALUE_WAIT: begin
        if (b == xts_pkg::CH_QUOT || b == xts_pkg::CH_APOS) begin
          s.quote = b;
          s.b_start = pn;
          s.mode = xts_pkg::M_VALUE_QUOTED;
        end else if (!ws) begin
          s.b_start = pos;
          s.mode = xts_pkg::M_VALUE_PLAIN;
          r.again = 1'b1;
        end
      end
      xts_pkg::M_VALUE_QUOTED: begin
        if (b == s.quote) begin
          r.emit = 1'b1;
          r.tok = mk(xts_pkg::TK_ATTR, s.a_start, s.a_len, s.b_start,
                     len_to(s.b_start, pos), 1'b1);
          s.mode = xts_pkg::M_TAG_IDLE;
        end
      end
      xts_pkg::M_VALUE_PLAIN: begin
        if (ws || b == xts_pkg::CH_GT || b == xts_pkg::CH_SLASH) begin
          r.emit = 1'b1;
          r.tok = mk(xts_pkg::TK_ATTR, s.a_start, s.a_len, s.b_start,
                     len_to(s.b_start, pos), 1'b1);
          s.mode = xts_pkg::M_TAG_IDLE;
          r.again = 1'b1;
        end
      end
      default: begin
        s.mode = xts_pkg::M_TEXT;
        s.a_start = pn;
        s.nonblank = 1'b0;
        r.again = 1'b1;
      end
    endcase
    r.sc = s;
    return r;
  endfunction

  // pending token at end of document
  function automatic pass_t finish(scan_t s, logic [PB-1:0] pos);
    pass_t r;
    r = '0;
    r.sc = s;
    r.emit = 1'b1;
    case (s.mode)
      xts_pkg::M_TEXT: begin
        r.emit = s.nonblank;
        r.tok = mk(xts_pkg::TK_TEXT, '0, '0, s.a_start, len_to(s.a_start, pos), 1'b0);
      end
      xts_pkg::M_LT, xts_pkg::M_BANG:
        r.tok = mk(xts_pkg::TK_START, pos, '0, '0, '0, 1'b0);
      xts_pkg::M_BANG_DASH, xts_pkg::M_TAG_NAME:
        r.tok = mk(xts_pkg::TK_START, s.a_start, len_to(s.a_start, pos), '0, '0, 1'b0);
      xts_pkg::M_CLOSE:
        r.tok = mk(xts_pkg::TK_CLOSE, s.a_start, len_to(s.a_start, pos), '0, '0, 1'b0);
      xts_pkg::M_DECL:
        r.tok = mk(xts_pkg::TK_DECL, '0, '0, s.a_start, len_to(s.a_start, pos), 1'b0);
      xts_pkg::M_COMMENT:
        r.tok = mk(xts_pkg::TK_COMMENT, '0, '0, s.a_start, len_to(s.a_start, pos), 1'b0);
      xts_pkg::M_ATTR_NAME:
        r.tok = mk(xts_pkg::TK_ATTR, s.a_start, len_to(s.a_start, pos), '0, '0, 1'b0);
      xts_pkg::M_ATTR_AFTER:
        r.tok = mk(xts_pkg::TK_ATTR, s.a_start, s.a_len, '0, '0, 1'b0);
      xts_pkg::M_VALUE_WAIT:
        r.tok = mk(xts_pkg::TK_ATTR, s.a_start, s.a_len, pos, '0, 1'b1);
      xts_pkg::M_VALUE_QUOTED, xts_pkg::M_VALUE_PLAIN:
        r.tok = mk(xts_pkg::TK_ATTR, s.a_start, s.a_len, s.b_start,
                   len_to(s.b_start, pos), 1'b1);
      default: begin
        r.emit = 1'b0;
        r.tok = '0;
      end
    endcase
    return r;
  endfunction

  pass_t           pass [5];
  pass_t           fin_pass;
  logic            fin;
  logic [1:0]      n_tok;
  xts_pkg::token_t t0;
  xts_pkg::token_t t1;

  assign fin = end_of_input || (byte_in == 8'h00);

  // re-dispatch chain, at most four passes per byte
  always_comb begin
    pass[0] = '0;
    pass[0].sc = state;
    pass[0].again = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (pass[i].again) begin
        pass[i+1] = run(pass[i], byte_in, position);
      end else begin
        pass[i+1] = pass[i];
        pass[i+1].emit = 1'b0;
      end
    end
  end

  assign fin_pass = finish(state, position);

  // gather emitted tokens into two slots
  always_comb begin
    n_tok = '0;
    t0 = '0;
    t1 = '0;
    if (fin) begin
      if (fin_pass.emit) begin
        t0 = fin_pass.tok;
        t1 = mk(xts_pkg::TK_EOF, '0, '0, '0, '0, 1'b0);
        t1.last = 1'b1;
        n_tok = 2'd2;
      end else begin
        t0 = mk(xts_pkg::TK_EOF, '0, '0, '0, '0, 1'b0);
        t0.last = 1'b1;
        n_tok = 2'd1;
      end
    end else begin
      for (int i = 1; i < 5; i++) begin
        if (pass[i].emit) begin
          if (n_tok == 2'd0) begin
            t0 = pass[i].tok;
          end else begin
            t1 = pass[i].tok;
          end
          n_tok = n_tok + 2'd1;
        end
      end
      if (n_tok == 2'd1) t0.last = 1'b1;
      if (n_tok == 2'd2) t1.last = 1'b1;
    end
  end

  always_comb begin
    push.count = (accept && !end_sent) ? n_tok : 2'd0;
    push.tok0 = t0;
    push.tok1 = t1;
  end

  // scanner state, all-zero reset is text mode with nothing pending
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      position <= '0;
      end_sent <= 1'b0;
    end else if (accept && !end_sent) begin
      if (fin) begin
        end_sent <= 1'b1;
      end else begin
        state <= pass[4].sc;
        position <= sat_inc(position);
      end
    end
  end

endmodule
`default_nettype wire

>>> design/xts_queue.sv
// xts_queue: token queue between scanner and output stage
// takes up to two tokens per cycle, gives one; depends on xts_pkg
`timescale 1ns / 1ps
`default_nettype none
module xts_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  xts_pkg::push_t       push,
  input  wire logic            pop,
  output xts_pkg::token_t      head,
  output logic                 nonempty,
  output xts_pkg::qstat_t      stat
);

  xts_pkg::token_t           mem [xts_pkg::Q_DEPTH];
  logic [xts_pkg::Q_AW-1:0]  wr_ptr;
  logic [xts_pkg::Q_AW-1:0]  rd_ptr;
  logic [xts_pkg::Q_LW-1:0]  level;
  logic                      do_pop;

  assign nonempty = (level != '0);
  assign do_pop = pop && nonempty;
  assign head = mem[rd_ptr];
  assign stat.level = level;

  // storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.tok0;
    if (push.count == 2'd2) mem[wr_ptr + 1'b1] <= push.tok1;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      wr_ptr <= wr_ptr + xts_pkg::Q_AW'(push.count);
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      level <= level + xts_pkg::Q_LW'(push.count) - xts_pkg::Q_LW'(do_pop);
    end
  end

endmodule
`default_nettype wire

>>> design/xts_back.sv
// xts_back: output register of the token channel
// pulls tokens from the queue and holds them under stall; depends on xts_pkg
`timescale 1ns / 1ps
`default_nettype none
module xts_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  xts_pkg::token_t  head,
  input  wire logic        nonempty,
  output logic             pop,
  input  wire logic        out_stall,
  output logic             out_valid,
  output xts_pkg::token_t  out_tok
);

  assign pop = nonempty && (!out_valid || !out_stall);

  // payload
  always_ff @(posedge clk) begin
    if (pop) out_tok <= head;
  end

  // valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> design/xml_token_scanner.sv
// xml_token_scanner: top level of the streaming xml tokenizer
// joins xts_front, xts_queue and xts_back; depends on xts_pkg
`timescale 1ns / 1ps
`default_nettype none
// The scanner takes one document byte per clock and turns it into span tokens
// (offset and length) for text, tags, attributes, declarations and comments.
// A byte is scanned in the cycle it is accepted; its tokens (none, one or two)
// go into a four-entry queue and leave through a registered output one per
// cycle while the output is not stalled; each token passes the queue memory
// and then the output register. Bytes are taken every cycle while the queue
// has room for two more tokens; only a run of bytes that each make two tokens,
// or a stalled output, slows the input down. Byte value zero or end_of_input
// ends the document: the pending token and an end token are sent, and later
// bytes are taken and dropped until reset.
module xml_token_scanner #(
  parameter int POSITION_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  byte_in,
  input  wire logic        end_of_input,
  output logic             token_valid,
  input  wire logic        token_stall,
  output logic [3:0]       token_type,
  output logic [23:0]      name_start,
  output logic [23:0]      name_length,
  output logic [23:0]      value_start,
  output logic [23:0]      value_length,
  output logic             has_value,
  output logic             last_of_run
);

  xts_pkg::push_t  push;
  xts_pkg::qstat_t stat;
  xts_pkg::token_t head;
  xts_pkg::token_t out_tok;
  logic            nonempty;
  logic            pop;
  logic            accept;

  // room for two tokens is needed before a byte is taken
  assign byte_stall = (stat.level > xts_pkg::Q_LW'(xts_pkg::Q_DEPTH - 2));
  assign accept = byte_valid && !byte_stall;

  xts_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .byte_in(byte_in),
    .end_of_input(end_of_input), .push(push)
  );

  xts_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .pop(pop), .head(head),
    .nonempty(nonempty), .stat(stat)
  );

  xts_back u_back (
    .clk(clk), .rst(rst), .head(head), .nonempty(nonempty), .pop(pop),
    .out_stall(token_stall), .out_valid(token_valid), .out_tok(out_tok)
  );

  assign token_type   = out_tok.ttype;
  assign name_start   = out_tok.name_start;
  assign name_length  = out_tok.name_length;
  assign value_start  = out_tok.value_start;
  assign value_length = out_tok.value_length;
  assign has_value    = out_tok.has_value;
  assign last_of_run  = out_tok.last;

  // queue never overfills
  a_level: assert property (@(posedge clk) disable iff (rst)
    stat.level <= xts_pkg::Q_LW'(xts_pkg::Q_DEPTH))
    else $error("token queue overfilled");

  // end token closes its run
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_type == xts_pkg::TK_EOF |-> last_of_run)
    else $error("end token not last of run");

  // nothing follows a delivered end token
  a_eof_final: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_stall && token_type == xts_pkg::TK_EOF |=> !token_valid)
    else $error("token after end token");

endmodule
`default_nettype wire
